@@ rtl/core/fba_pkg.sv @@
// Shared sizes, field widths, codes and reset values for the frame bitmap allocator.
package fba_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = MAX_FRAMES / WORD_BITS;

    localparam int FRAME_W = 12;
    localparam int LIMIT_W = 13;
    localparam int STATUS_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_DONE = 2'd0;
    localparam status_t STATUS_NOP = 2'd1;
    localparam status_t STATUS_FULL = 2'd2;

endpackage

@@ rtl/core/frame_bitmap_allocator.sv @@
// Bitmap page frame allocator: first-fit allocate and free over a used-frame memory.
//
// Request beats arrive on s_valid/s_ready: s_kind selects allocate or free, s_page_frame
// is the frame the page entry holds now, s_is_kernel and s_is_writable give the entry
// flags. Every request gives exactly one result beat on m_valid/m_ready.
// An allocate for an entry holding no frame scans the used map one word per cycle,
// words 0 .. min(frame_limit/WORD_BITS, MAP_WORDS) - 1, reading the map memory at one
// word per cycle with registered read data; the lowest free frame is marked used and
// returned. When no frame in that range is free, the result is STATUS_FULL. A free reads
// the word, then clears the frame's bit and writes the word back; requests that need no
// map access go straight to the result. One request is in flight at a time; a new one
// is taken the cycle after the previous result loads into the output register, even if
// it is not yet taken. A stalled receiver holds the result beat; the next result waits
// for the slot. The frame limit is written through cfg_valid/cfg_ready; the user must
// write it only while the block is idle, as the block itself does not enforce this.
// Reset clears the limit to 4096 and marks every map word free at once through
// per-word valid bits, so the block accepts requests right after reset.
module frame_bitmap_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fba_pkg::LIMIT_W-1:0]   cfg_frame_limit,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [fba_pkg::FRAME_W-1:0]   s_page_frame,
    input  logic                          s_is_kernel,
    input  logic                          s_is_writable,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fba_pkg::STATUS_W-1:0]  m_status,
    output logic [fba_pkg::FRAME_W-1:0]   m_new_frame,
    output logic                          m_present,
    output logic                          m_writable,
    output logic                          m_user_access
);
    import fba_pkg::*;

    localparam int WIDX = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNTW = $clog2(MAP_WORDS + 1);
    localparam int BIDX = $clog2(WORD_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_FREE_WR = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rd_valid_reg;
    logic [MAP_WORDS-1:0] valid_reg;

    logic                 mem_re;
    logic [WIDX-1:0]      mem_raddr;
    logic                 mem_we;
    logic [WIDX-1:0]      mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [2:0]           state_reg, state_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [CNTW-1:0]      words_reg, words_next;
    logic [CNTW-1:0]      scan_reg, scan_next;
    logic                 pend_reg, pend_next;
    logic [WIDX-1:0]      eval_addr_reg, eval_addr_next;
    logic [BIDX-1:0]      bit_reg, bit_next;
    logic                 kern_reg, kern_next;
    logic                 wr_reg, wr_next;

    status_t              res_status_reg, res_status_next;
    logic [FRAME_W-1:0]   res_frame_reg, res_frame_next;
    logic                 res_present_reg, res_present_next;
    logic                 res_writable_reg, res_writable_next;
    logic                 res_user_reg, res_user_next;

    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg;
    logic [FRAME_W-1:0]   m_frame_reg;
    logic                 m_present_reg;
    logic                 m_writable_reg;
    logic                 m_user_reg;
    logic                 m_load;

    logic [31:0]          lim_words;
    logic [31:0]          free_word;
    logic                 issue;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] low_zero;
    logic [BIDX-1:0]      low_idx;
    logic [31:0]          found_frame;

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_new_frame = m_frame_reg;
    assign m_present = m_present_reg;
    assign m_writable = m_writable_reg;
    assign m_user_access = m_user_reg;

    assign lim_words = 32'(limit_reg) >> BIDX;
    assign free_word = 32'(s_page_frame) >> BIDX;
    assign issue = (scan_reg < words_reg);
    assign cur_word = rd_valid_reg ? rdata_reg : '0;
    assign low_zero = ~cur_word & (cur_word + WORD_BITS'(1));
    assign found_frame = (32'(eval_addr_reg) << BIDX) | 32'(low_idx);

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (low_zero[i]) begin
                low_idx = low_idx | BIDX'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        words_next = words_reg;
        scan_next = scan_reg;
        pend_next = 1'b0;
        eval_addr_next = eval_addr_reg;
        bit_next = bit_reg;
        kern_next = kern_reg;
        wr_next = wr_reg;
        res_status_next = res_status_reg;
        res_frame_next = res_frame_reg;
        res_present_next = res_present_reg;
        res_writable_next = res_writable_reg;
        res_user_next = res_user_reg;
        mem_re = 1'b0;
        mem_raddr = scan_reg[WIDX-1:0];
        mem_we = 1'b0;
        mem_waddr = eval_addr_reg;
        mem_wdata = cur_word | low_zero;
        m_load = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kern_next = s_is_kernel;
                    wr_next = s_is_writable;
                    res_status_next = STATUS_DONE;
                    res_frame_next = '0;
                    res_present_next = 1'b0;
                    res_writable_next = 1'b0;
                    res_user_next = 1'b0;
                    state_next = ST_DONE;
                    if (s_kind == KIND_ALLOC) begin
                        if (s_page_frame != '0) begin
                            res_status_next = STATUS_NOP;
                            res_frame_next = s_page_frame;
                        end else if (lim_words == 32'd0) begin
                            res_status_next = STATUS_FULL;
                        end else begin
                            words_next = (lim_words > 32'(MAP_WORDS)) ?
                                CNTW'(MAP_WORDS) : CNTW'(lim_words);
                            scan_next = '0;
                            state_next = ST_SCAN;
                        end
                    end else begin
                        if (s_page_frame == '0) begin
                            res_status_next = STATUS_NOP;
                        end else if (free_word < 32'(MAP_WORDS)) begin
                            mem_re = 1'b1;
                            mem_raddr = free_word[WIDX-1:0];
                            eval_addr_next = free_word[WIDX-1:0];
                            bit_next = s_page_frame[BIDX-1:0];
                            state_next = ST_FREE_WR;
                        end
                    end
                end
            end
            ST_SCAN: begin
                mem_re = issue;
                pend_next = issue;
                eval_addr_next = scan_reg[WIDX-1:0];
                if (issue) begin
                    scan_next = scan_reg + CNTW'(1);
                end
                if (pend_reg && (cur_word != '1)) begin
                    mem_we = 1'b1;
                    res_status_next = STATUS_DONE;
                    res_frame_next = found_frame[FRAME_W-1:0];
                    res_present_next = 1'b1;
                    res_writable_next = wr_reg;
                    res_user_next = ~kern_reg;
                    state_next = ST_DONE;
                end else if (!issue) begin
                    res_status_next = STATUS_FULL;
                    state_next = ST_DONE;
                end
            end
            ST_FREE_WR: begin
                mem_we = 1'b1;
                mem_wdata = cur_word & ~(WORD_BITS'(1) << bit_reg);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg && !m_ready;
        if (m_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= map_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            limit_reg <= LIMIT_RESET;
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                limit_reg <= cfg_frame_limit;
            end
            if (mem_re) begin
                rd_valid_reg <= valid_reg[mem_raddr];
            end
            if (mem_we) begin
                valid_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        words_reg <= words_next;
        scan_reg <= scan_next;
        eval_addr_reg <= eval_addr_next;
        bit_reg <= bit_next;
        kern_reg <= kern_next;
        wr_reg <= wr_next;
        res_status_reg <= res_status_next;
        res_frame_reg <= res_frame_next;
        res_present_reg <= res_present_next;
        res_writable_reg <= res_writable_next;
        res_user_reg <= res_user_next;
        if (m_load) begin
            m_status_reg <= res_status_reg;
            m_frame_reg <= res_frame_reg;
            m_present_reg <= res_present_reg;
            m_writable_reg <= res_writable_reg;
            m_user_reg <= res_user_reg;
        end
    end

endmodule

@@ bench/frame_bitmap_allocator_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the frame bitmap allocator: directed table, then random phases.
module frame_bitmap_allocator_test;
    import fba_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int SETTLE_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD = 300;
    localparam int DIRECTED_ROWS = 23;

    typedef enum logic {STEP_REQ, STEP_LIMIT} step_t;

    typedef struct packed {
        logic               kind;
        logic [FRAME_W-1:0] frame;
        logic               kernel;
        logic               writable;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [FRAME_W-1:0] new_frame;
        logic               present;
        logic               writable;
        logic               user_access;
    } entry_t;

    typedef struct packed {
        step_t              step;
        request_t           req;
        logic [LIMIT_W-1:0] limit;
        logic               typed;
        entry_t             entry;
    } plan_row_t;

    localparam request_t NO_REQ = '0;
    localparam entry_t NO_ENTRY = '0;

    localparam plan_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
        '{STEP_REQ, '{KIND_ALLOC, 12'd0, 1'b0, 1'b1}, 13'd0, 1'b1,
          '{STATUS_DONE, 12'd0, 1'b1, 1'b1, 1'b1}},
        '{STEP_REQ, '{KIND_ALLOC, 12'd0, 1'b1, 1'b0}, 13'd0, 1'b1,
          '{STATUS_DONE, 12'd1, 1'b1, 1'b0, 1'b0}},
        '{STEP_REQ, '{KIND_ALLOC, 12'd4095, 1'b0, 1'b1}, 13'd0, 1'b1,
          '{STATUS_NOP, 12'd4095, 1'b0, 1'b0, 1'b0}},
        '{STEP_REQ, '{KIND_ALLOC, 12'd1, 1'b1, 1'b1}, 13'd0, 1'b1,
          '{STATUS_NOP, 12'd1, 1'b0, 1'b0, 1'b0}},
        '{STEP_REQ, '{KIND_FREE, 12'd0, 1'b0, 1'b0}, 13'd0, 1'b1,
          '{STATUS_NOP, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{STEP_REQ, '{KIND_FREE, 12'd1, 1'b1, 1'b1}, 13'd0, 1'b1,
          '{STATUS_DONE, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{STEP_REQ, '{KIND_ALLOC, 12'd0, 1'b0, 1'b0}, 13'd0, 1'b0, NO_ENTRY},
        '{STEP_REQ, '{KIND_FREE, 12'd4095, 1'b1, 1'b0}, 13'd0, 1'b1,
          '{STATUS_DONE, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{STEP_REQ, '{KIND_FREE, 12'd2, 1'b0, 1'b1}, 13'd0, 1'b1,
          '{STATUS_DONE, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{STEP_LIMIT, NO_REQ, 13'd0, 1'b0, NO_ENTRY},
        '{STEP_REQ, '{KIND_ALLOC, 12'd0, 1'b0, 1'b1}, 13'd0, 1'b1,
          '{STATUS_FULL, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{STEP_REQ, '{KIND_FREE, 12'd1, 1'b0, 1'b0}, 13'd0, 1'b1,
          '{STATUS_DONE, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{STEP_LIMIT, NO_REQ, 13'd31, 1'b0, NO_ENTRY},
        '{STEP_REQ, '{KIND_ALLOC, 12'd0, 1'b1, 1'b1}, 13'd0, 1'b1,
          '{STATUS_FULL, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{STEP_REQ, '{KIND_ALLOC, 12'd2048, 1'b1, 1'b1}, 13'd0, 1'b1,
          '{STATUS_NOP, 12'd2048, 1'b0, 1'b0, 1'b0}},
        '{STEP_LIMIT, NO_REQ, 13'd32, 1'b0, NO_ENTRY},
        '{STEP_REQ, '{KIND_ALLOC, 12'd0, 1'b1, 1'b1}, 13'd0, 1'b0, NO_ENTRY},
        '{STEP_REQ, '{KIND_ALLOC, 12'd0, 1'b0, 1'b0}, 13'd0, 1'b0, NO_ENTRY},
        '{STEP_LIMIT, NO_REQ, 13'd8191, 1'b0, NO_ENTRY},
        '{STEP_REQ, '{KIND_ALLOC, 12'd0, 1'b1, 1'b1}, 13'd0, 1'b0, NO_ENTRY},
        '{STEP_LIMIT, NO_REQ, 13'd4096, 1'b0, NO_ENTRY},
        '{STEP_REQ, '{KIND_ALLOC, 12'd0, 1'b0, 1'b1}, 13'd0, 1'b0, NO_ENTRY},
        '{STEP_REQ, '{KIND_FREE, 12'd3, 1'b0, 1'b0}, 13'd0, 1'b0, NO_ENTRY}
    };

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_frame_limit;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic [FRAME_W-1:0] s_page_frame;
    logic               s_is_kernel;
    logic               s_is_writable;
    logic               m_valid;
    logic               m_ready;
    status_t            m_status;
    logic [FRAME_W-1:0] m_new_frame;
    logic               m_present;
    logic               m_writable;
    logic               m_user_access;

    logic [WORD_BITS-1:0] frame_used [MAP_WORDS];
    logic [LIMIT_W-1:0]   frame_limit_model;
    int                   held_frames [$];
    entry_t               entry_updates_due [$];
    int                   errors = 0;
    int                   sent = 0;
    int                   stuck_cycles = 0;
    bit                   steady = 1'b0;
    bit                   hold_req = 1'b0;

    frame_bitmap_allocator uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_frame_limit(cfg_frame_limit),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_page_frame(s_page_frame),
        .s_is_kernel(s_is_kernel),
        .s_is_writable(s_is_writable),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_new_frame(m_new_frame),
        .m_present(m_present),
        .m_writable(m_writable),
        .m_user_access(m_user_access)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic entry_t predict_entry_update(request_t r);
        entry_t e;
        int     words;
        int     pick;
        e = '0;
        pick = -1;
        if (r.kind == KIND_ALLOC) begin
            if (r.frame != 0) begin
                e.status = STATUS_NOP;
                e.new_frame = r.frame;
            end else begin
                words = (frame_limit_model > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit_model);
                words = words / WORD_BITS;
                for (int w = 0; w < words && pick < 0; w++) begin
                    for (int b = 0; b < WORD_BITS && pick < 0; b++) begin
                        if (!frame_used[w][b]) pick = w * WORD_BITS + b;
                    end
                end
                if (pick < 0) begin
                    e.status = STATUS_FULL;
                end else begin
                    frame_used[pick / WORD_BITS][pick % WORD_BITS] = 1'b1;
                    if (pick != 0) held_frames.push_back(pick);
                    e.status = STATUS_DONE;
                    e.new_frame = pick[FRAME_W-1:0];
                    e.present = 1'b1;
                    e.writable = r.writable;
                    e.user_access = !r.kernel;
                end
            end
        end else if (r.frame == 0) begin
            e.status = STATUS_NOP;
        end else begin
            frame_used[r.frame / WORD_BITS][r.frame % WORD_BITS] = 1'b0;
            for (int i = 0; i < held_frames.size(); i++) begin
                if (held_frames[i] == int'(r.frame)) begin
                    held_frames.delete(i);
                    break;
                end
            end
            e.status = STATUS_DONE;
        end
        return e;
    endfunction

    task automatic send_request(request_t r, logic typed, entry_t typed_entry);
        int     gap;
        entry_t e;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= r.kind;
        s_page_frame <= r.frame;
        s_is_kernel <= r.kernel;
        s_is_writable <= r.writable;
        do @(posedge aclk); while (!s_ready);
        e = predict_entry_update(r);
        entry_updates_due.push_back(typed ? typed_entry : e);
        sent++;
    endtask

    task automatic write_frame_limit(logic [LIMIT_W-1:0] value);
        s_valid <= 1'b0;
        while (entry_updates_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_frame_limit <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        frame_limit_model = value;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        entry_t want;
        if (aresetn && m_valid && m_ready) begin
            if (entry_updates_due.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, got status %0d frame %0d",
                         $time, m_status, m_new_frame);
                errors++;
            end else begin
                want = entry_updates_due.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("new_frame", 32'(want.new_frame), 32'(m_new_frame));
                check_field("present", 32'(want.present), 32'(m_present));
                check_field("writable", 32'(want.writable), 32'(m_writable));
                check_field("user_access", 32'(want.user_access), 32'(m_user_access));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        int hold_left;
        m_ready = 1'b0;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        request_t           r;
        int                 roll;
        int                 phase;
        logic [LIMIT_W-1:0] lim;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_frame_limit = '0;
        s_valid = 1'b0;
        s_kind = KIND_ALLOC;
        s_page_frame = '0;
        s_is_kernel = 1'b0;
        s_is_writable = 1'b0;
        foreach (frame_used[w]) frame_used[w] = '0;
        frame_limit_model = LIMIT_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_PLAN[i]) begin
            if (DIRECTED_PLAN[i].step == STEP_LIMIT) begin
                write_frame_limit(DIRECTED_PLAN[i].limit);
            end else begin
                send_request(DIRECTED_PLAN[i].req, DIRECTED_PLAN[i].typed,
                             DIRECTED_PLAN[i].entry);
            end
        end

        phase = 0;
        while (sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            case (phase)
                0: lim = 13'd32;
                1: lim = 13'd8191;
                2: lim = 13'd64;
                default: begin
                    roll = $urandom_range(0, 9);
                    if (roll == 0) lim = LIMIT_W'($urandom_range(0, 31));
                    else if (roll == 1) lim = 13'd4096;
                    else if (roll == 2) lim = 13'd8191;
                    else if (roll == 3) lim = LIMIT_W'($urandom_range(0, 8191));
                    else lim = LIMIT_W'(32 * $urandom_range(1, 8) + $urandom_range(0, 31));
                end
            endcase
            write_frame_limit(lim);
            steady = (phase % 5 == 3);
            if (phase == 2) hold_req = 1'b1;
            for (int n = $urandom_range(40, 120); n > 0; n--) begin
                r.kernel = 1'($urandom_range(0, 1));
                r.writable = 1'($urandom_range(0, 1));
                r.frame = '0;
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    r.kind = KIND_ALLOC;
                end else if (roll < 75 && held_frames.size() != 0) begin
                    r.kind = KIND_FREE;
                    r.frame = FRAME_W'(held_frames[$urandom_range(0, held_frames.size() - 1)]);
                end else if (roll < 85) begin
                    r.kind = KIND_ALLOC;
                    r.frame = FRAME_W'($urandom_range(0, 4095));
                end else if (roll < 95) begin
                    r.kind = KIND_FREE;
                    r.frame = FRAME_W'($urandom_range(0, 4095));
                end else begin
                    r.kind = KIND_FREE;
                end
                send_request(r, 1'b0, NO_ENTRY);
            end
            phase++;
        end

        s_valid <= 1'b0;
        while (entry_updates_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ frame_bitmap_allocator.f @@
rtl/core/fba_pkg.sv
rtl/core/frame_bitmap_allocator.sv
bench/frame_bitmap_allocator_test.sv
